// ===== hw/rtl/lodh_pkg.sv =====
// Shared constants, types and helper functions for the level-of-detail selector.
package lodh_pkg;

  localparam int NUM_CELLS   = 1024;
  localparam int MAX_LEVEL   = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int RANGE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 10;
  localparam int OUT_LVL_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int LVL_W   = $clog2(MAX_LEVEL + 1);
  localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam longint POW3_MAX = 3 ** MAX_LEVEL;
  localparam int     POW3_W   = $clog2(POW3_MAX + 1);
  localparam int     RPROD_W  = RANGE_W + POW3_W;

  // Boundaries saturate at 2^48, so one extra bit above 48.
  localparam int BOUND_W = 49;
  localparam int BMUL_W  = BOUND_W - 1;
  localparam logic [BOUND_W-1:0] BOUND_SAT = {1'b1, {BMUL_W{1'b0}}};

  localparam int LO_W   = 32 + FRAC_W;
  localparam int HI_W   = (BMUL_W - 32) + FRAC_W;
  localparam int PROD_W = BMUL_W + FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_RANGE = 1'b0,
    CFG_HYST_FRAC  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_DECIDE,
    BK_CLEAR,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic               is_clear;
    logic               in_table;
    logic [IDX_W-1:0]   idx;
    logic [RANGE_W-1:0] range;
    logic [LVL_W-1:0]   nominal;
  } item_t;

  // 3^k for k in 0..MAX_LEVEL, as a small constant table.
  function automatic logic [POW3_W-1:0] pow3(input logic [LVL_W-1:0] k);
    logic [POW3_W-1:0] p;
    logic [POW3_W-1:0] res;
    p   = POW3_W'(1);
    res = '0;
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (LVL_W'(i) == k) begin
        res = p;
      end
      p = POW3_W'(p * POW3_W'(3));
    end
    return res;
  endfunction

  // r0 * 3^k, saturated at 2^48.
  function automatic logic [BOUND_W-1:0] bound_of(input logic [RANGE_W-1:0] r0,
                                                  input logic [LVL_W-1:0]   k);
    logic [RPROD_W-1:0] p;
    p = RPROD_W'(r0) * RPROD_W'(pow3(k));
    if (64'(p) >= 64'(BOUND_SAT)) begin
      return BOUND_SAT;
    end
    return BOUND_W'(p);
  endfunction

endpackage

// ===== hw/rtl/lod_select_with_hysteresis_unit.sv =====
// Top level of the terrain level-of-detail selector with hysteresis.
//
// Each input beat either evaluates one terrain cell (func_i = 0) or clears all
// committed levels (func_i = 1), and every beat produces exactly one result
// beat, in order. The nominal level is 0 below base_range and otherwise the k
// with base_range*3^(k-1) <= slant_range < base_range*3^k, capped at the top
// level; a per-cell table keeps a valid mark and the committed level, and a
// visited cell only moves to the nominal level once the range clears the
// relevant boundary widened by the Q0.16 hysteresis fraction. The front end
// computes the nominal level in the cycle an item is taken and places it in a
// two-entry queue; the back end works on one item at a time. An evaluate beat
// for a cell out of the table goes straight to the result, one for a new cell
// or a cell already at its nominal level needs one table read, and otherwise
// the hysteresis test runs (one table read, a 32x16 and then a 16x16 product
// for the scaled boundary, one compare); each result may then wait for the
// output register to free up. A clear beat sweeps the table one entry per
// cycle. After reset the same sweep runs over all NUM_CELLS entries (1024
// with the default table), and in_ready_o stays low during every sweep;
// configuration writes are taken at any time and should only be issued while
// the block is idle. The output register lets the next item proceed while a
// finished result still waits for out_ready_i.
module lod_select_with_hysteresis_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [lodh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lodh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [lodh_pkg::IDX_W-1:0]      cell_index_i,
  input  logic [lodh_pkg::RANGE_W-1:0]    slant_range_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lodh_pkg::OUT_LVL_W-1:0]  lod_level_o,
  output logic [lodh_pkg::OUT_LVL_W-1:0]  nominal_level_o,
  output logic                            level_changed_o
);

  logic [lodh_pkg::RANGE_W-1:0] base_range_q;
  logic [lodh_pkg::FRAC_W-1:0]  hyst_frac_q;

  logic            push_valid, push_ready;
  lodh_pkg::item_t push_data;
  logic            pop_valid, pop_ready;
  lodh_pkg::item_t pop_data;
  logic            sweep_busy;

  // Configuration registers. Reset values give a 1000 m level-zero range and
  // a hysteresis band of about ten percent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_range_q <= lodh_pkg::RANGE_W'(64000);
      hyst_frac_q  <= lodh_pkg::FRAC_W'(6554);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lodh_pkg::CFG_BASE_RANGE: begin
          base_range_q <= cfg_data_i[lodh_pkg::RANGE_W-1:0];
        end
        lodh_pkg::CFG_HYST_FRAC: begin
          hyst_frac_q <= cfg_data_i[lodh_pkg::FRAC_W-1:0];
        end
        default: begin
          base_range_q <= base_range_q;
        end
      endcase
    end
  end

  // Front end: nominal level and item classification.
  lodh_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .cell_index_i  (cell_index_i),
    .slant_range_i (slant_range_i),
    .base_range_i  (base_range_q),
    .sweep_busy_i  (sweep_busy),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // Decoupling queue between the two halves.
  lodh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: table lookup, hysteresis decision and result register.
  lodh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .base_range_i    (base_range_q),
    .hyst_frac_i     (hyst_frac_q),
    .sweep_busy_o    (sweep_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lod_level_o     (lod_level_o),
    .nominal_level_o (nominal_level_o),
    .level_changed_o (level_changed_o)
  );

endmodule

// ===== hw/rtl/lodh_front.sv =====
// Front end: takes input beats, computes the nominal level and classifies the item.
module lodh_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [lodh_pkg::IDX_W-1:0]    cell_index_i,
  input  logic [lodh_pkg::RANGE_W-1:0]  slant_range_i,
  input  logic [lodh_pkg::RANGE_W-1:0]  base_range_i,
  input  logic                          sweep_busy_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output lodh_pkg::item_t               push_data_o
);

  logic [lodh_pkg::LVL_W-1:0] nominal;
  logic [lodh_pkg::LVL_W-1:0] above_cnt;

  // The boundaries rise with k, so at or above base_range the level is one plus
  // the number of upper boundaries that the range reaches; below it, it is 0.
  always_comb begin
    above_cnt = '0;
    for (int j = 1; j < lodh_pkg::MAX_LEVEL; j++) begin
      if (lodh_pkg::BOUND_W'(slant_range_i) >=
          lodh_pkg::bound_of(base_range_i, lodh_pkg::LVL_W'(j))) begin
        above_cnt = above_cnt + lodh_pkg::LVL_W'(1);
      end
    end
    if (slant_range_i < base_range_i) begin
      nominal = '0;
    end else begin
      nominal = above_cnt + lodh_pkg::LVL_W'(1);
    end
  end

  assign in_ready_o   = push_ready_i && !sweep_busy_i;
  assign push_valid_o = in_valid_i && !sweep_busy_i;

  always_comb begin
    push_data_o          = '0;
    push_data_o.is_clear = func_i;
    push_data_o.in_table = (32'(cell_index_i) < 32'(lodh_pkg::NUM_CELLS));
    push_data_o.idx      = cell_index_i;
    push_data_o.range    = slant_range_i;
    push_data_o.nominal  = nominal;
  end

endmodule

// ===== hw/rtl/lodh_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
module lodh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lodh_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lodh_pkg::item_t pop_data_o
);

  lodh_pkg::item_t               entry_q [lodh_pkg::QUEUE_DEPTH];
  logic [lodh_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lodh_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lodh_pkg::QPTR_W:0]     count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = (count_q != (lodh_pkg::QPTR_W + 1)'(lodh_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == lodh_pkg::QPTR_W'(lodh_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + lodh_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == lodh_pkg::QPTR_W'(lodh_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + lodh_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + (lodh_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (lodh_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/lodh_back.sv =====
// Back end: per-cell table, hysteresis test, table sweeps and the result register.
module lodh_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  lodh_pkg::item_t                pop_data_i,
  input  logic [lodh_pkg::RANGE_W-1:0]   base_range_i,
  input  logic [lodh_pkg::FRAC_W-1:0]    hyst_frac_i,
  output logic                           sweep_busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lodh_pkg::OUT_LVL_W-1:0] lod_level_o,
  output logic [lodh_pkg::OUT_LVL_W-1:0] nominal_level_o,
  output logic                           level_changed_o
);

  localparam int LW = lodh_pkg::LVL_W;
  localparam int AW = lodh_pkg::CELL_AW;
  localparam int BW = lodh_pkg::BOUND_W;

  lodh_pkg::bk_state_e state_q, state_d;

  // Table word: valid mark on top, committed level below.
  logic [LW:0]    cell_mem_q [lodh_pkg::NUM_CELLS];
  logic [LW:0]    rdata_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [LW:0]    mem_wdata;
  logic [AW-1:0]  mem_raddr;

  logic [AW-1:0]                  sweep_cnt_q, sweep_cnt_d;
  logic [lodh_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [lodh_pkg::RANGE_W-1:0]   range_q, range_d;
  logic [LW-1:0]                  nom_q, nom_d;
  logic [LW-1:0]                  cur_q, cur_d;
  logic                           up_q, up_d;
  logic [BW-1:0]                  bound_q, bound_d;
  logic [lodh_pkg::LO_W-1:0]      lo_q, lo_d;
  logic [lodh_pkg::HI_W-1:0]      hi_q, hi_d;
  logic [LW-1:0]                  res_lod_q, res_lod_d;
  logic [LW-1:0]                  res_nom_q, res_nom_d;
  logic                           res_chg_q, res_chg_d;
  logic                           out_valid_q, out_valid_d;
  logic [lodh_pkg::OUT_LVL_W-1:0] out_lod_q, out_lod_d;
  logic [lodh_pkg::OUT_LVL_W-1:0] out_nom_q, out_nom_d;
  logic                           out_chg_q, out_chg_d;

  always_comb begin
    logic                             rd_valid;
    logic [LW-1:0]                    rd_level;
    logic [LW-1:0]                    k_sel;
    logic [lodh_pkg::PROD_W-1:0]      prod;
    logic [lodh_pkg::BMUL_W-1:0]      diff;
    logic                             pass;

    state_d     = state_q;
    sweep_cnt_d = sweep_cnt_q;
    idx_d       = idx_q;
    range_d     = range_q;
    nom_d       = nom_q;
    cur_d       = cur_q;
    up_d        = up_q;
    bound_d     = bound_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_lod_d   = res_lod_q;
    res_nom_d   = res_nom_q;
    res_chg_d   = res_chg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_lod_d   = out_lod_q;
    out_nom_d   = out_nom_q;
    out_chg_d   = out_chg_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(idx_q);
    mem_wdata   = {1'b1, nom_q};
    mem_raddr   = AW'(pop_data_i.idx);
    rd_valid    = rdata_q[LW];
    rd_level    = rdata_q[LW-1:0];
    k_sel       = '0;
    prod        = '0;
    diff        = '0;
    pass        = 1'b0;

    case (state_q)
      lodh_pkg::BK_INIT, lodh_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = sweep_cnt_q;
        mem_wdata   = '0;
        sweep_cnt_d = sweep_cnt_q + AW'(1);
        if (sweep_cnt_q == AW'(lodh_pkg::NUM_CELLS - 1)) begin
          sweep_cnt_d = '0;
          state_d     = (state_q == lodh_pkg::BK_CLEAR) ? lodh_pkg::BK_EMIT :
                                                           lodh_pkg::BK_IDLE;
        end
      end
      lodh_pkg::BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          idx_d   = pop_data_i.idx;
          range_d = pop_data_i.range;
          nom_d   = pop_data_i.nominal;
          if (pop_data_i.is_clear) begin
            res_lod_d = '0;
            res_nom_d = '0;
            res_chg_d = 1'b0;
            state_d   = lodh_pkg::BK_CLEAR;
          end else if (!pop_data_i.in_table) begin
            res_lod_d = pop_data_i.nominal;
            res_nom_d = pop_data_i.nominal;
            res_chg_d = 1'b0;
            state_d   = lodh_pkg::BK_EMIT;
          end else begin
            state_d = lodh_pkg::BK_READ;
          end
        end
      end
      lodh_pkg::BK_READ: begin
        res_nom_d = nom_q;
        if (!rd_valid) begin
          mem_we    = 1'b1;
          res_lod_d = nom_q;
          res_chg_d = 1'b1;
          state_d   = lodh_pkg::BK_EMIT;
        end else if (rd_level == nom_q) begin
          res_lod_d = rd_level;
          res_chg_d = 1'b0;
          state_d   = lodh_pkg::BK_EMIT;
        end else begin
          cur_d   = rd_level;
          up_d    = (nom_q > rd_level);
          k_sel   = (nom_q > rd_level) ? rd_level : rd_level - LW'(1);
          bound_d = lodh_pkg::bound_of(base_range_i, k_sel);
          state_d = lodh_pkg::BK_MUL_LO;
        end
      end
      lodh_pkg::BK_MUL_LO: begin
        lo_d    = lodh_pkg::LO_W'(bound_q[31:0]) * lodh_pkg::LO_W'(hyst_frac_i);
        state_d = lodh_pkg::BK_MUL_HI;
      end
      lodh_pkg::BK_MUL_HI: begin
        hi_d    = lodh_pkg::HI_W'(bound_q[lodh_pkg::BMUL_W-1:32]) *
                  lodh_pkg::HI_W'(hyst_frac_i);
        state_d = lodh_pkg::BK_DECIDE;
      end
      lodh_pkg::BK_DECIDE: begin
        prod = lodh_pkg::PROD_W'(lo_q) + {hi_q, 32'b0};
        if (up_q) begin
          // r*65536 > b*(65536+h)  <=>  (r-b)*65536 > b*h, with b <= r.
          diff = lodh_pkg::BMUL_W'(range_q) - bound_q[lodh_pkg::BMUL_W-1:0];
          pass = (bound_q <= BW'(range_q)) &&
                 ({diff, {lodh_pkg::FRAC_W{1'b0}}} > prod);
        end else begin
          // r*65536 < b*(65536-h)  <=>  (b-r)*65536 > b*h, with b > r.
          diff = bound_q[lodh_pkg::BMUL_W-1:0] - lodh_pkg::BMUL_W'(range_q);
          pass = bound_q[BW-1] ||
                 ((bound_q > BW'(range_q)) &&
                  ({diff, {lodh_pkg::FRAC_W{1'b0}}} > prod));
        end
        if (pass) begin
          mem_we    = 1'b1;
          res_lod_d = nom_q;
          res_chg_d = 1'b1;
        end else begin
          res_lod_d = cur_q;
          res_chg_d = 1'b0;
        end
        state_d = lodh_pkg::BK_EMIT;
      end
      lodh_pkg::BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_lod_d   = lodh_pkg::OUT_LVL_W'(res_lod_q);
          out_nom_d   = lodh_pkg::OUT_LVL_W'(res_nom_q);
          out_chg_d   = res_chg_q;
          state_d     = lodh_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = lodh_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lodh_pkg::BK_INIT;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    range_q   <= range_d;
    nom_q     <= nom_d;
    cur_q     <= cur_d;
    up_q      <= up_d;
    bound_q   <= bound_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_lod_q <= res_lod_d;
    res_nom_q <= res_nom_d;
    res_chg_q <= res_chg_d;
    out_lod_q <= out_lod_d;
    out_nom_q <= out_nom_d;
    out_chg_q <= out_chg_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cell_mem_q[mem_raddr];
  end

  assign sweep_busy_o    = (state_q == lodh_pkg::BK_INIT) || (state_q == lodh_pkg::BK_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign lod_level_o     = out_lod_q;
  assign nominal_level_o = out_nom_q;
  assign level_changed_o = out_chg_q;

  // An item is only taken from the queue while no other item is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o) |-> (state_q == lodh_pkg::BK_IDLE))
    else $error("queue popped outside idle state");

  // The table read data is consumed in the cycle after the address was set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lodh_pkg::BK_READ) |-> ($past(state_q) == lodh_pkg::BK_IDLE))
    else $error("table data used without a preceding read");

  // A changed level is always the nominal level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && level_changed_o) |-> (lod_level_o == nominal_level_o))
    else $error("changed level differs from nominal level");

  // No table update is written while the block waits for an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lodh_pkg::BK_IDLE) |-> !mem_we)
    else $error("table written in idle state");

endmodule
